// File: design/assert_macros.svh
// assertion macros shared by the compositor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define PTCC_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ptcc assertion failed");

// condition holds in the following cycle
`define PTCC_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ptcc assertion failed");

`endif

// File: design/ptcc_pkg.sv
// types, constants and codes of the character cell compositor
package ptcc_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;

    localparam logic [ADDR_BITS-1:0] CELL_LAST = ADDR_BITS'(CELL_COUNT - 1);
    localparam logic [7:0]  MAX_COLS_W   = 8'(MAX_COLUMNS);
    localparam logic [6:0]  MAX_ROWS_H   = 7'(MAX_ROWS);
    localparam logic [7:0]  WIDTH_RESET  = 8'd80;
    localparam logic [6:0]  HEIGHT_RESET = 7'd25;
    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0a;
    localparam logic [15:0] OFFSET_MAX   = 16'hffff;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // work kinds handed from front to back
    localparam logic [1:0] KIND_NOP   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_DRAW  = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic               first_char;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [15:0]        color;
        logic signed [15:0] priority_req;
        logic [7:0]         text_char;
        logic [6:0]         read_col;
        logic [5:0]         read_row;
    } cmd_t;

    typedef struct packed {
        logic [7:0]         cell_char;
        logic [15:0]        cell_attr;
        logic signed [15:0] cell_priority;
        logic               wrote_cell;
    } result_t;

    typedef struct packed {
        logic [7:0]         glyph;
        logic [15:0]        attr;
        logic signed [15:0] prio;
    } cell_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ADDR_BITS-1:0] addr;
        cell_t                entry;
    } work_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    localparam cell_t BLANK_CELL = '{glyph: BLANK_CHAR, attr: 16'h0000, prio: -16'sd1};

endpackage

// File: design/ptcc_front.sv
// front end: configuration, command offsets, clipping and classification
module ptcc_front
    import ptcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  cmd_t       cmd,
    input  logic       wr_en,
    input  logic       wr_index,
    input  logic [7:0] wr_data,
    output logic       push,
    output work_t      work
);

    logic [7:0]  width_reg;
    logic [6:0]  height_reg;
    logic [15:0] col_reg, col_next;
    logic [15:0] line_reg, line_next;
    logic        drop_reg, drop_next;

    logic [7:0]  eff_w;
    logic [6:0]  eff_h;
    logic [15:0] col_base, line_base;
    logic        drop_v, visible;
    logic [17:0] x_sum, y_sum;

    assign eff_w = (width_reg > MAX_COLS_W) ? MAX_COLS_W : width_reg;
    assign eff_h = (height_reg > MAX_ROWS_H) ? MAX_ROWS_H : height_reg;

    assign col_base  = cmd.first_char ? 16'h0000 : col_reg;
    assign line_base = cmd.first_char ? 16'h0000 : line_reg;
    assign drop_v    = cmd.first_char
                       ? (cmd.origin_y[15] || (cmd.origin_y[14:0] >= {8'b0, eff_h}))
                       : drop_reg;

    // origin plus offset never leaves an 18-bit signed range
    assign x_sum = {{2{cmd.origin_x[15]}}, cmd.origin_x} + {2'b00, col_base};
    assign y_sum = {{2{cmd.origin_y[15]}}, cmd.origin_y} + {2'b00, line_base};

    assign visible = !x_sum[17] && (x_sum[16:0] < {9'b0, eff_w})
                  && !y_sum[17] && (y_sum[16:0] < {10'b0, eff_h});

    always_comb
    begin
        col_next   = col_reg;
        line_next  = line_reg;
        drop_next  = drop_reg;
        push       = accept;
        work.kind  = KIND_NOP;
        work.addr  = {cmd.read_row, cmd.read_col};
        work.entry = '{glyph: cmd.text_char, attr: cmd.color, prio: cmd.priority_req};
        if (accept)
        begin
            case (cmd.opcode)
                OP_CLEAR:
                begin
                    work.kind = KIND_CLEAR;
                end
                OP_DRAW:
                begin
                    col_next  = col_base;
                    line_next = line_base;
                    drop_next = drop_v;
                    work.addr = {y_sum[ROW_BITS-1:0], x_sum[COL_BITS-1:0]};
                    if (!drop_v)
                    begin
                        if (cmd.text_char == NEWLINE_CHAR)
                        begin
                            col_next = 16'h0000;
                            if (line_base != OFFSET_MAX)
                                line_next = line_base + 16'd1;
                        end
                        else
                        begin
                            if (col_base != OFFSET_MAX)
                                col_next = col_base + 16'd1;
                            if (visible)
                                work.kind = KIND_DRAW;
                        end
                    end
                end
                OP_READ:
                begin
                    work.kind = KIND_READ;
                end
                default:
                begin
                    work.kind = KIND_NOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= 16'h0000;
            line_reg   <= 16'h0000;
            drop_reg   <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
            drop_reg <= drop_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_SCREEN_WIDTH:  width_reg  <= wr_data;
                    REG_SCREEN_HEIGHT: height_reg <= wr_data[6:0];
                    default:           width_reg  <= width_reg;
                endcase
            end
        end
    end

endmodule

// File: design/ptcc_queue.sv
// short work queue between front and back end
`include "assert_macros.svh"

module ptcc_queue
    import ptcc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_work,
    input  logic  pop,
    output work_t head,
    output logic  empty,
    output logic  full
);

    work_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_work;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `PTCC_ASSERT_IMP(a_no_overflow, push, !full)
    `PTCC_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

// File: design/ptcc_back.sv
// back end: frame store, clearing sweep, priority tested write and cell read
`include "assert_macros.svh"

module ptcc_back
    import ptcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  work_t        head,
    output logic         pop,
    output back_status_t status,
    output logic         done,
    output result_t      result
);

    localparam logic [1:0] S_INIT   = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SWEEP  = 2'd2;
    localparam logic [1:0] S_ACCESS = 2'd3;

    cell_t store [CELL_COUNT];

    logic [1:0]           state_reg, state_next;
    logic [ADDR_BITS-1:0] sweep_reg, sweep_next;
    work_t                cur_reg, cur_next;
    cell_t                rd_reg;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    cell_t                mem_wdata;

    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        cur_next    = cur_reg;
        pop         = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = sweep_reg;
        mem_wdata   = BLANK_CELL;
        done_next   = 1'b0;
        result_next = '0;
        case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == CELL_LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    case (head.kind)
                        KIND_CLEAR:
                        begin
                            state_next = S_SWEEP;
                            sweep_next = '0;
                        end
                        KIND_DRAW, KIND_READ:
                        begin
                            state_next = S_ACCESS;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == CELL_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ACCESS:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (cur_reg.kind == KIND_READ)
                begin
                    result_next.cell_char     = rd_reg.glyph;
                    result_next.cell_attr     = rd_reg.attr;
                    result_next.cell_priority = rd_reg.prio;
                end
                else if (!(rd_reg.prio > cur_reg.entry.prio))
                begin
                    // stored cell does not outrank the command
                    mem_we                 = 1'b1;
                    mem_waddr              = cur_reg.addr;
                    mem_wdata              = cur_reg.entry;
                    result_next.wrote_cell = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_waddr] <= mem_wdata;
        rd_reg <= store[head.addr];
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    assign status.init_busy = (state_reg == S_INIT);
    assign done             = done_reg;
    assign result           = result_reg;

    `PTCC_ASSERT_IMP(a_no_write_idle, mem_we, state_reg != S_IDLE)
    `PTCC_ASSERT_NXT(a_quiet_init, state_reg == S_INIT, !done_reg)
    `PTCC_ASSERT_NXT(a_access_once, state_reg == S_ACCESS, done_reg && state_reg == S_IDLE)

endmodule

// File: design/priority_text_cell_compositor.sv
// with an empty queue, a read or a draw landing on screen gives its result after the queue slot,
// the pop in the idle state and the access state; other draws and unused opcodes from the idle state
// a read or on-screen draw holds the back end in the idle and access states (store read, then for
// a draw the priority tested write), other draws the idle state only; a clear sweeps all 8192 cells
// a 4-entry queue lets items be accepted while the back end works; busy is high while it is full
// after reset the store is swept to all 8192 blank cells with busy high; config still writes
// results are strobed on done for one cycle each and cannot be held off
module priority_text_cell_compositor
    import ptcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  cmd_t       cmd,
    input  logic       wr_en,
    input  logic       wr_index,
    input  logic [7:0] wr_data,
    output logic       done,
    output result_t    result
);

    logic         accept;
    logic         push;
    work_t        push_work;
    work_t        head;
    logic         pop;
    logic         q_empty;
    logic         q_full;
    back_status_t status;

    assign busy   = q_full || status.init_busy;
    assign accept = start && !busy;

    ptcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (cmd),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .work     (push_work)
    );

    ptcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_work (push_work),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    ptcc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .status  (status),
        .done    (done),
        .result  (result)
    );

endmodule

// File: bench/priority_text_cell_compositor_check.sv
// result checker for the character cell compositor: tracks the frame store and compares results
`timescale 1ns / 100ps

module priority_text_cell_compositor_check
    import ptcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  cmd_t       cmd,
    input  logic       wr_en,
    input  logic       wr_index,
    input  logic [7:0] wr_data,
    input  logic       done,
    input  result_t    result,
    output int         pending,
    output int         mismatches,
    output int         cells_drawn
);

    cell_t      frame [CELL_COUNT];
    logic [7:0] scr_width;
    logic [6:0] scr_height;
    int         col_off;
    int         line_off;
    logic       cmd_dropped;
    result_t    awaited [$];

    function automatic void blank_frame();
        foreach (frame[i])
            frame[i] = BLANK_CELL;
    endfunction

    function automatic logic place_glyph(input cmd_t c);
        int ox;
        int oy;
        int x;
        int y;
        int w;
        int h;
        int idx;
        ox = $signed(c.origin_x);
        oy = $signed(c.origin_y);
        w  = (scr_width < MAX_COLUMNS) ? int'(scr_width) : MAX_COLUMNS;
        h  = (scr_height < MAX_ROWS) ? int'(scr_height) : MAX_ROWS;
        if (c.first_char)
        begin
            col_off     = 0;
            line_off    = 0;
            cmd_dropped = (oy < 0 || oy >= h);
        end
        if (cmd_dropped)
            return 1'b0;
        if (c.text_char == NEWLINE_CHAR)
        begin
            if (line_off < OFFSET_MAX)
                line_off++;
            col_off = 0;
            return 1'b0;
        end
        x = ox + col_off;
        y = oy + line_off;
        if (col_off < OFFSET_MAX)
            col_off++;
        if (x < 0 || x >= w || y < 0 || y >= h)
            return 1'b0;
        idx = y * MAX_COLUMNS + x;
        // stored cell wins only when strictly higher
        if ($signed(frame[idx].prio) > $signed(c.priority_req))
            return 1'b0;
        frame[idx] = '{glyph: c.text_char, attr: c.color, prio: c.priority_req};
        return 1'b1;
    endfunction

    function automatic result_t predict_result(input cmd_t c);
        result_t r;
        int      idx;
        r = '0;
        case (c.opcode)
            OP_CLEAR: blank_frame();
            OP_DRAW:  r.wrote_cell = place_glyph(c);
            OP_READ:
            begin
                idx             = int'(c.read_row) * MAX_COLUMNS + int'(c.read_col);
                r.cell_char     = frame[idx].glyph;
                r.cell_attr     = frame[idx].attr;
                r.cell_priority = frame[idx].prio;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        logic    bad;
        if (!rst_n)
        begin
            blank_frame();
            scr_width   = WIDTH_RESET;
            scr_height  = HEIGHT_RESET;
            col_off     = 0;
            line_off    = 0;
            cmd_dropped = 1'b0;
            awaited.delete();
            pending     = 0;
            mismatches  = 0;
            cells_drawn = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, result);
                    mismatches++;
                end
                else
                begin
                    want = awaited.pop_front();
                    bad  = 1'b0;
                    if (result.cell_char !== want.cell_char)
                    begin
                        $display("%0t: cell_char expected %02h, got %02h",
                                 $time, want.cell_char, result.cell_char);
                        bad = 1'b1;
                    end
                    if (result.cell_attr !== want.cell_attr)
                    begin
                        $display("%0t: cell_attr expected %04h, got %04h",
                                 $time, want.cell_attr, result.cell_attr);
                        bad = 1'b1;
                    end
                    if (result.cell_priority !== want.cell_priority)
                    begin
                        $display("%0t: cell_priority expected %0d, got %0d", $time,
                                 $signed(want.cell_priority), $signed(result.cell_priority));
                        bad = 1'b1;
                    end
                    if (result.wrote_cell !== want.wrote_cell)
                    begin
                        $display("%0t: wrote_cell expected %0b, got %0b",
                                 $time, want.wrote_cell, result.wrote_cell);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches++;
                end
            end
            if (wr_en)
            begin
                case (wr_index)
                    REG_SCREEN_WIDTH:  scr_width  = wr_data;
                    REG_SCREEN_HEIGHT: scr_height = wr_data[6:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                want = predict_result(cmd);
                if (want.wrote_cell)
                    cells_drawn++;
                awaited.push_back(want);
            end
            pending = awaited.size();
        end
    end

endmodule

// File: bench/priority_text_cell_compositor_test.sv
// stimulus and verdict for the character cell compositor
`timescale 1ns / 100ps

module priority_text_cell_compositor_test;
    import ptcc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         PHASE_ITEMS = 52;
    localparam int         PLAN_COUNT  = 10;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       start    = 1'b0;
    cmd_t       cmd      = '0;
    logic       wr_en    = 1'b0;
    logic       wr_index = REG_SCREEN_WIDTH;
    logic [7:0] wr_data  = '0;
    logic       busy;
    logic       done;
    result_t    result;

    int pending;
    int mismatches;
    int cells_drawn;
    int cycle_count = 0;

    int eff_w = 80;
    int eff_h = 25;
    bit steady = 1'b0;
    int sent = 0;
    int n_draw = 0;
    int n_read = 0;
    int n_clear = 0;
    int n_unused = 0;
    int n_settings = 1;

    // screen settings run in turn, extremes included
    int plan_w [PLAN_COUNT] = '{1, 128, 0, 33, 255, 12, 80, 128, 7, 0};
    int plan_h [PLAN_COUNT] = '{1, 64, 7, 0, 127, 6, 25, 64, 3, 0};

    always #2 clk = ~clk;

    priority_text_cell_compositor DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .done     (done),
        .result   (result)
    );

    priority_text_cell_compositor_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .done        (done),
        .result      (result),
        .pending     (pending),
        .mismatches  (mismatches),
        .cells_drawn (cells_drawn)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("priority_text_cell_compositor: mismatch");
            $finish;
        end
    end

    function automatic cmd_t bare_item(input logic [1:0] op);
        logic [127:0] raw;
        cmd_t         c;
        raw      = {$urandom(), $urandom(), $urandom(), $urandom()};
        c        = raw[$bits(cmd_t)-1:0];
        c.opcode = op;
        return c;
    endfunction

    function automatic cmd_t draw_item(input logic first, input int ox, input int oy,
                                       input logic [15:0] color, input int prio,
                                       input logic [7:0] ch);
        cmd_t c;
        c              = bare_item(OP_DRAW);
        c.first_char   = first;
        c.origin_x     = 16'(ox);
        c.origin_y     = 16'(oy);
        c.color        = color;
        c.priority_req = 16'(prio);
        c.text_char    = ch;
        return c;
    endfunction

    function automatic cmd_t read_at(input int col, input int row);
        cmd_t c;
        c          = bare_item(OP_READ);
        c.read_col = 7'(col);
        c.read_row = 6'(row);
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge; returns at a falling edge once taken, after any gap
    task automatic send(input cmd_t c);
        int gap;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        sent++;
        case (c.opcode)
            OP_CLEAR: n_clear++;
            OP_DRAW:  n_draw++;
            OP_READ:  n_read++;
            default:  n_unused++;
        endcase
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic settle(input int tail);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic program_screen(input int w, input int h);
        wr_en    <= 1'b1;
        wr_index <= REG_SCREEN_WIDTH;
        wr_data  <= 8'(w);
        @(negedge clk);
        wr_index <= REG_SCREEN_HEIGHT;
        wr_data  <= 8'(h);
        @(negedge clk);
        wr_en    <= 1'b0;
        eff_w = (w < MAX_COLUMNS) ? w : MAX_COLUMNS;
        eff_h = (h < MAX_ROWS) ? h : MAX_ROWS;
    endtask

    task automatic random_read();
        int col;
        int row;
        if ($urandom_range(0, 7) == 0)
        begin
            col = $urandom_range(0, MAX_COLUMNS - 1);
            row = $urandom_range(0, MAX_ROWS - 1);
        end
        else
        begin
            col = $urandom_range(0, (eff_w + 1 < MAX_COLUMNS) ? eff_w + 1 : MAX_COLUMNS - 1);
            row = $urandom_range(0, (eff_h + 1 < MAX_ROWS) ? eff_h + 1 : MAX_ROWS - 1);
        end
        send(read_at(col, row));
    endtask

    // one text command: a start item then its continuation, mostly near the screen
    task automatic write_command();
        int          ox;
        int          oy;
        int          prio;
        int          len;
        int          r;
        logic [15:0] color;
        logic [7:0]  ch;
        if ($urandom_range(0, 6) == 0)
        begin
            ox = $signed(16'($urandom()));
            oy = $signed(16'($urandom()));
        end
        else
        begin
            ox = int'($urandom_range(0, eff_w + 5)) - 3;
            oy = int'($urandom_range(0, eff_h + 2)) - 1;
        end
        if ($urandom_range(0, 4) == 0)
            prio = $signed(16'($urandom()));
        else
            prio = int'($urandom_range(0, 8)) - 4;
        color = 16'($urandom());
        len   = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                ch = NEWLINE_CHAR;
            else if (r < 18)
                ch = 8'h00;
            else
                ch = 8'($urandom_range(0, 255));
            send(draw_item(k == 0, ox, oy, color, prio, ch));
            if ($urandom_range(0, 19) == 0)
                random_read();
        end
    endtask

    initial
    begin
        int w;
        int h;
        int target;
        int r;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part on the reset screen of 80 x 25
        send(read_at(0, 0));
        send(read_at(MAX_COLUMNS - 1, MAX_ROWS - 1));
        send(draw_item(1'b1, 78, 0, 16'hffff, 0, "A"));
        send(draw_item(1'b0, 78, 0, 16'hffff, 0, "B"));
        send(draw_item(1'b0, 78, 0, 16'hffff, 0, "Z"));
        send(draw_item(1'b0, 78, 0, 16'hffff, 0, NEWLINE_CHAR));
        send(draw_item(1'b0, 78, 0, 16'hffff, 0, 8'h00));
        send(read_at(79, 0));
        send(read_at(78, 1));
        // lower priority loses, equal wins, highest wins
        send(draw_item(1'b1, 78, 0, 16'h0000, -32768, "x"));
        send(draw_item(1'b1, 79, 0, 16'h1234, 0, "y"));
        send(draw_item(1'b1, 78, 0, 16'h8001, 32767, "w"));
        send(read_at(78, 0));
        // origin row above and below the screen drops the command
        send(draw_item(1'b1, 5, -1, 16'h5555, 3, "q"));
        send(draw_item(1'b0, 5, 3, 16'h5555, 3, "r"));
        send(draw_item(1'b1, 0, 25, 16'haaaa, 3, "s"));
        // later row falls off the bottom, then a continuation with its own origin
        send(draw_item(1'b1, 0, 24, 16'h00ff, 1, "a"));
        send(draw_item(1'b0, 0, 24, 16'h00ff, 1, NEWLINE_CHAR));
        send(draw_item(1'b0, 0, 24, 16'h00ff, 1, "b"));
        send(draw_item(1'b0, 2, 3, 16'h0f0f, 1, "c"));
        send(draw_item(1'b1, -32768, 32767, 16'h7fff, -1, "d"));
        send(draw_item(1'b1, 32767, 0, 16'h7fff, -1, "e"));
        send(bare_item(OP_UNUSED));
        send(bare_item(OP_CLEAR));
        send(read_at(79, 0));

        for (int p = 0; p < PLAN_COUNT + 2; p++)
        begin
            if (p < PLAN_COUNT)
            begin
                w = plan_w[p];
                h = plan_h[p];
            end
            else
            begin
                w = $urandom_range(1, MAX_COLUMNS);
                h = $urandom_range(1, MAX_ROWS);
            end
            settle(4);
            program_screen(w, h);
            n_settings++;
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                send(bare_item(OP_CLEAR));
            target = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                if ($urandom_range(0, 40) == 0)
                    steady = !steady;
                r = $urandom_range(0, 99);
                if (r < 62)
                    write_command();
                else if (r < 90)
                    random_read();
                else if (r < 96)
                    // stray continuation with arbitrary fields
                    send(draw_item(1'b0, $signed(16'($urandom())), $signed(16'($urandom())),
                                   16'($urandom()), $signed(16'($urandom())),
                                   8'($urandom())));
                else
                    send(bare_item(OP_UNUSED));
            end
        end

        settle(16);
        $display("run covered %0d items: %0d draw, %0d read, %0d clear, %0d unused opcode",
                 sent, n_draw, n_read, n_clear, n_unused);
        $display("%0d screen settings used, %0d cells drawn", n_settings, cells_drawn);
        if (mismatches == 0 && pending == 0)
            $display("priority_text_cell_compositor: match");
        else
            $display("priority_text_cell_compositor: mismatch");
        $finish;
    end

endmodule

// File: priority_text_cell_compositor.f
+incdir+design
design/ptcc_pkg.sv
design/ptcc_front.sv
design/ptcc_queue.sv
design/ptcc_back.sv
design/priority_text_cell_compositor.sv
bench/priority_text_cell_compositor_check.sv
bench/priority_text_cell_compositor_test.sv
